[sv/nbu_pkg.sv]
// ----------------------------------------------------------------------------
// Neuron backprop unit package
// Shared widths, operation codes, controller states, the command bundle
// between controller and datapath, saturation and the sigmoid table builder.
// ----------------------------------------------------------------------------
package nbu_pkg;

  localparam int DATA_W      = 16;
  localparam int FRAC_W      = 12;
  localparam int ACC_W       = 40;
  localparam int ETA_W       = 16;
  localparam int OP_W        = 3;
  localparam int TBL_DEPTH   = 256;
  localparam int TBL_IDX_W   = $clog2(TBL_DEPTH);
  localparam int SIG_IN_LOG2 = 3;
  localparam int EXP_W       = 30;

  localparam int SUM_Q_W    = ACC_W - FRAC_W;
  localparam int DER_W      = 2 * DATA_W - FRAC_W - 1;
  localparam int MUL_X_W    = 2 * DATA_W;
  localparam int MUL_Y_W    = DER_W;
  localparam int PROD_W     = MUL_X_W + MUL_Y_W;
  localparam int SIG_LIM_SH = SIG_IN_LOG2 + 2 * FRAC_W;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_LEARNING_RATE = '0;
  localparam logic [ETA_W-1:0]      ETA_RESET         = 16'd655;

  typedef enum logic [OP_W-1:0] {
    OP_ACC = 3'd0,
    OP_ACT = 3'd1,
    OP_HID = 3'd2,
    OP_ODL = 3'd3,
    OP_UPD = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_AB,
    ST_ACC,
    ST_MUL_SQ,
    ST_MUL_FIN,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    MS_AB,
    MS_AA,
    MS_CC,
    MS_BC,
    MS_SUM_DER,
    MS_DIFF_DER,
    MS_PROD_ETA
  } mul_sel_t;

  typedef enum logic [1:0] {
    RS_SIG,
    RS_SCALED,
    RS_UPD
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_add;
    logic     acc_clr;
    logic     out_load;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     flag;
  } sat_res_t;

  typedef logic [TBL_DEPTH*DATA_W-1:0] sig_table_t;

  function automatic sat_res_t sat_data(input logic signed [PROD_W-1:0] v);
    localparam logic signed [PROD_W-1:0] DATA_MAX = (1 <<< (DATA_W - 1)) - 1;
    localparam logic signed [PROD_W-1:0] DATA_MIN = -DATA_MAX - 1;
    sat_res_t r;
    r.flag  = 1'b0;
    r.value = v[DATA_W-1:0];
    if (v > DATA_MAX) begin
      r.flag  = 1'b1;
      r.value = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < DATA_MIN) begin
      r.flag  = 1'b1;
      r.value = {1'b1, {(DATA_W-1){1'b0}}};
    end
    return r;
  endfunction

  // Restoring long division, used only while the table is built.
  function automatic longint unsigned long_div(input longint unsigned n,
                                               input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[62:0], n[j]};
      if (r >= d) begin
        r    = r - d;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // Each entry is the bipolar sigmoid at the midpoint of its input interval.
  // The exponential is built in Q30 integers; the entries are rounded, not exact.
  function automatic sig_table_t sig_build();
    sig_table_t               tbl;
    longint unsigned          one;
    longint unsigned          half;
    longint unsigned          term;
    longint unsigned          q;
    longint unsigned          u;
    longint unsigned          base;
    longint unsigned          f;
    longint unsigned          e;
    logic signed [DATA_W-1:0] ent;
    int                       d;
    tbl  = '0;
    one  = 64'd1 << EXP_W;
    half = 64'd1 << (EXP_W - 1);
    term = one;
    q    = one;
    for (int k = 1; k <= 20; k++) begin
      term = long_div(term * (64'd1 << SIG_IN_LOG2), 64'(TBL_DEPTH) * 64'(k));
      if (k[0]) begin
        q = q - term;
      end else begin
        q = q + term;
      end
    end
    for (int i = 0; i < TBL_DEPTH; i++) begin
      d    = 2 * i + 1 - TBL_DEPTH;
      e    = 64'((d < 0) ? -d : d);
      u    = one;
      base = q;
      for (int j = 0; j < TBL_IDX_W; j++) begin
        if (e[j]) begin
          u = (u * base + half) >> EXP_W;
        end
        base = (base * base + half) >> EXP_W;
      end
      f   = long_div(((one - u) << FRAC_W) + ((one + u) >> 1), one + u);
      ent = DATA_W'(f);
      if (d < 0) begin
        ent = -ent;
      end
      tbl[i*DATA_W +: DATA_W] = ent;
    end
    return tbl;
  endfunction

endpackage

[sv/nbu_ctrl.sv]
// ----------------------------------------------------------------------------
// Neuron backprop unit controller
// Sequences the shared multiplier, accumulator and result register per item.
// ----------------------------------------------------------------------------
module nbu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [nbu_pkg::OP_W-1:0] in_op,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nbu_pkg::dp_cmd_t     cmd
);
  import nbu_pkg::*;

  ctrl_state_t state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;
  logic        accept;

  function automatic ctrl_state_t first_state(input op_t op);
    ctrl_state_t s;
    unique case (op)
      OP_ACC, OP_ACT, OP_HID: s = ST_MUL_AB;
      OP_ODL, OP_UPD:         s = ST_MUL_SQ;
      default:                s = ST_IDLE;
    endcase
    return s;
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_MUL_AB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_AB;
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        in_ready    = (op_r == OP_ACC);
      end
      ST_MUL_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_add = (op_r == OP_HID);
        priority case (op_r)
          OP_HID:  cmd.mul_sel = MS_CC;
          OP_ODL:  cmd.mul_sel = MS_AA;
          default: cmd.mul_sel = MS_BC;
        endcase
      end
      ST_MUL_FIN: begin
        cmd.mul_en = 1'b1;
        priority case (op_r)
          OP_HID:  cmd.mul_sel = MS_SUM_DER;
          OP_ODL:  cmd.mul_sel = MS_DIFF_DER;
          default: cmd.mul_sel = MS_PROD_ETA;
        endcase
      end
      ST_OUT: begin
        in_ready     = out_free;
        cmd.out_load = out_free;
        cmd.acc_clr  = out_free && ((op_r == OP_ACT) || (op_r == OP_HID));
        priority case (op_r)
          OP_ACT:  cmd.res_sel = RS_SIG;
          OP_UPD:  cmd.res_sel = RS_UPD;
          default: cmd.res_sel = RS_SCALED;
        endcase
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.load = accept;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      ST_IDLE:    state_nxt = ST_IDLE;
      ST_MUL_AB:  state_nxt = (op_r == OP_HID) ? ST_MUL_SQ : ST_ACC;
      ST_ACC:     state_nxt = (op_r == OP_ACT) ? ST_OUT : ST_IDLE;
      ST_MUL_SQ:  state_nxt = ST_MUL_FIN;
      ST_MUL_FIN: state_nxt = ST_OUT;
      ST_OUT:     state_nxt = out_free ? ST_IDLE : ST_OUT;
      default:    state_nxt = ST_IDLE;
    endcase
    if (accept) begin
      op_nxt    = op_t'(in_op);
      state_nxt = first_state(op_t'(in_op));
    end
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/nbu_dp.sv]
// ----------------------------------------------------------------------------
// Neuron backprop unit datapath
// Operand registers, one shared signed multiplier, the wide accumulator,
// the sigmoid table and the saturating result register.
// ----------------------------------------------------------------------------
module nbu_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nbu_pkg::dp_cmd_t                    cmd,
  input  logic [nbu_pkg::ETA_W-1:0]           eta,
  input  logic signed [nbu_pkg::DATA_W-1:0]   in_a,
  input  logic signed [nbu_pkg::DATA_W-1:0]   in_b,
  input  logic signed [nbu_pkg::DATA_W-1:0]   in_c,
  output logic signed [nbu_pkg::DATA_W-1:0]   res_value,
  output logic                                res_sat
);
  import nbu_pkg::*;

  localparam sig_table_t SIG_TABLE = sig_build();
  localparam logic signed [2*DATA_W:0] ONE_SQ = (2*DATA_W+1)'(1) << (2 * FRAC_W);

  logic signed [DATA_W-1:0]  a_r, b_r, c_r;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [DATA_W-1:0]  res_r;
  logic                      sat_r;
  logic signed [2*DATA_W:0]  der_num;
  logic signed [DER_W-1:0]   der;
  logic signed [SUM_Q_W-1:0] sum_q;
  logic signed [DATA_W:0]    diff;
  logic signed [MUL_X_W-1:0] mul_x;
  logic signed [MUL_Y_W-1:0] mul_y;
  logic                      in_rng;
  logic [TBL_IDX_W-1:0]      idx;
  logic signed [DATA_W-1:0]  sig_val;
  logic signed [PROD_W-1:0]  res_pre;
  sat_res_t                  res_nxt;

  always_comb begin
    der_num = ONE_SQ - $signed(prod_r[2*DATA_W:0]);
    der     = DER_W'(der_num >>> (FRAC_W + 1));
    sum_q   = $signed(acc_r[ACC_W-1:FRAC_W]);
    diff    = (DATA_W+1)'(a_r) - (DATA_W+1)'(b_r);
    unique case (cmd.mul_sel)
      MS_AB: begin
        mul_x = MUL_X_W'(a_r);
        mul_y = MUL_Y_W'(b_r);
      end
      MS_AA: begin
        mul_x = MUL_X_W'(a_r);
        mul_y = MUL_Y_W'(a_r);
      end
      MS_CC: begin
        mul_x = MUL_X_W'(c_r);
        mul_y = MUL_Y_W'(c_r);
      end
      MS_BC: begin
        mul_x = MUL_X_W'(b_r);
        mul_y = MUL_Y_W'(c_r);
      end
      MS_SUM_DER: begin
        mul_x = MUL_X_W'(sum_q);
        mul_y = der;
      end
      MS_DIFF_DER: begin
        mul_x = MUL_X_W'(diff);
        mul_y = der;
      end
      MS_PROD_ETA: begin
        mul_x = $signed(prod_r[MUL_X_W-1:0]);
        mul_y = $signed(MUL_Y_W'({1'b0, eta}));
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
    prod_nxt = mul_x * mul_y;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_clr) begin
      acc_nxt = '0;
    end else if (cmd.acc_add) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_comb begin
    in_rng = (&acc_r[ACC_W-1:SIG_LIM_SH]) || !(|acc_r[ACC_W-1:SIG_LIM_SH]);
    if (in_rng) begin
      idx = {~acc_r[SIG_LIM_SH], acc_r[SIG_LIM_SH-1 -: TBL_IDX_W-1]};
    end else if (acc_r[ACC_W-1]) begin
      idx = '0;
    end else begin
      idx = '1;
    end
    sig_val = SIG_TABLE[idx*DATA_W +: DATA_W];
    unique case (cmd.res_sel)
      RS_SIG:    res_pre = PROD_W'(sig_val);
      RS_SCALED: res_pre = prod_r >>> FRAC_W;
      RS_UPD:    res_pre = PROD_W'(a_r) - (prod_r >>> (FRAC_W + ETA_W));
      default:   res_pre = '0;
    endcase
    res_nxt = sat_data(res_pre);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= in_a;
      b_r <= in_b;
      c_r <= in_c;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.out_load) begin
      res_r <= res_nxt.value;
      sat_r <= res_nxt.flag;
    end
  end

  assign res_value = res_r;
  assign res_sat   = sat_r;

endmodule

[sv/neuron_backprop_unit.sv]
// ----------------------------------------------------------------------------
// Neuron backprop unit
// Fixed-point neuron for perceptron training with a bipolar sigmoid.
// ----------------------------------------------------------------------------
// Items share a single signed multiplier; a new item is taken only while idle
// or in the last step of the item before it. The steps of an item are set by
// the multiplier steps it needs and its accumulate and result steps: hidden
// delta needs the most, plain accumulate the fewest, and unused operation codes
// give no result. The result sits in an output register and the next item is
// taken in the cycle the result is written; while an earlier result still
// waits there, the result step and the input stall until it is taken. Values
// are signed Q3.12; every result saturates to 16 bits and sets tuser when it
// does. The learning rate register sits at byte address 0 and resets to 655.
module neuron_backprop_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // value_a, value_b, value_c
  input  logic [2:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // result_value
  output logic        out_tuser,  // saturated
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [nbu_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import nbu_pkg::*;

  dp_cmd_t            cmd;
  logic [ETA_W-1:0]   eta_r, eta_nxt;
  logic               reg_hit;
  logic signed [DATA_W-1:0] res_value;

  assign reg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_LEARNING_RATE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? 32'(eta_r) : 32'd0;

  always_comb begin
    eta_nxt = eta_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      eta_nxt = cfg_pwdata[ETA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_r <= ETA_RESET;
    end else begin
      eta_r <= eta_nxt;
    end
  end

  nbu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  nbu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .eta       (eta_r),
    .in_a      ($signed(in_tdata[15:0])),
    .in_b      ($signed(in_tdata[31:16])),
    .in_c      ($signed(in_tdata[47:32])),
    .res_value (res_value),
    .res_sat   (out_tuser)
  );

  assign out_tdata = res_value;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid survived reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("waiting result changed before it was taken");

  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tready))
    else $error("unit not ready for input when writing a result");

endmodule
